[rtl/shp_pkg.sv]
`timescale 1ns / 1ps

package shp_pkg;

    localparam int unsigned POWER_W = 16;
    localparam int unsigned REPEAT_W = 8;
    localparam int unsigned COUNT_W = 16;

    localparam logic [15:0] SOC_LIMIT = 16'd95;
    localparam logic [15:0] PHASE_LIMIT = 16'd2500;
    localparam logic [15:0] POWER_RESET = 16'd300;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // item kinds
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // measurement register slots
    localparam logic [2:0] SLOT_VOLTAGE = 3'd0;
    localparam logic [2:0] SLOT_CHARGE = 3'd1;
    localparam logic [2:0] SLOT_CURRENT = 3'd2;
    localparam logic [2:0] SLOT_PHASE_A = 3'd3;
    localparam logic [2:0] SLOT_PHASE_B = 3'd4;
    localparam logic [2:0] SLOT_PHASE_C = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_POWER_STEP = 2'd0;
    localparam logic [1:0] CFG_MAX_POWER = 2'd1;
    localparam logic [1:0] CFG_REPEAT_INC = 2'd2;
    localparam logic [1:0] CFG_REPEAT_DEC = 2'd3;

    localparam logic [15:0] CFG_POWER_STEP_RST = 16'd0;
    localparam logic [15:0] CFG_MAX_POWER_RST = 16'd0;
    localparam logic [7:0] CFG_REPEAT_INC_RST = 8'd2;
    localparam logic [7:0] CFG_REPEAT_DEC_RST = 8'd4;

    typedef struct packed {
        logic [POWER_W-1:0]  power_step;
        logic [POWER_W-1:0]  max_power;
        logic [REPEAT_W-1:0] repeat_increase;
        logic [REPEAT_W-1:0] repeat_decrease;
    } t_cfg;

endpackage

[rtl/shp_ramp.sv]
`timescale 1ns / 1ps

module shp_ramp
    import shp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_kind,
    input  logic [2:0]         i_reg_index,
    input  logic [15:0]        i_reg_value,
    input  logic               i_heater_on,
    input  t_cfg               i_cfg,
    output logic               o_emit,
    output logic [POWER_W-1:0] o_setpoint
);

    logic [15:0]        r_charge_level;
    logic [15:0]        r_battery_current;
    logic [15:0]        r_phase_a;
    logic [15:0]        r_phase_b;
    logic [15:0]        r_phase_c;
    logic               r_data_valid;
    logic [POWER_W-1:0] r_heater_power;
    logic               r_last_was_up;
    logic [COUNT_W-1:0] r_run_count;

    logic [POWER_W-1:0] n_heater_power;
    logic               n_last_was_up;
    logic [COUNT_W-1:0] n_run_count;

    logic               surplus;
    logic               current_pos;
    logic               same_dir;
    logic [COUNT_W-1:0] bumped;
    logic [POWER_W:0]   sum;
    logic               is_tick;

    assign is_tick = i_accept && (i_kind == KIND_TICK);
    assign current_pos = !r_battery_current[15] && (r_battery_current != 16'd0);
    assign surplus = (r_charge_level > SOC_LIMIT) && current_pos
                  && (r_phase_a < PHASE_LIMIT) && (r_phase_b < PHASE_LIMIT)
                  && (r_phase_c < PHASE_LIMIT) && i_heater_on;

    assign same_dir = surplus ? r_last_was_up : !r_last_was_up;
    assign bumped = !same_dir ? '0
                  : (r_run_count == COUNT_MAX) ? r_run_count
                  : r_run_count + 1'b1;
    assign sum = {1'b0, r_heater_power} + {1'b0, i_cfg.power_step};

    always_comb begin
        n_heater_power = r_heater_power;
        n_last_was_up = surplus;
        n_run_count = bumped;
        if (surplus) begin
            if ((r_heater_power <= i_cfg.max_power)
                && (bumped >= {{(COUNT_W-REPEAT_W){1'b0}}, i_cfg.repeat_increase})) begin
                n_heater_power = (sum < {1'b0, i_cfg.max_power}) ? sum[POWER_W-1:0]
                                                                 : i_cfg.max_power;
                n_run_count = '0;
            end
        end else begin
            if ((r_heater_power != '0)
                && (bumped > {{(COUNT_W-REPEAT_W){1'b0}}, i_cfg.repeat_decrease})) begin
                n_heater_power = (r_heater_power > i_cfg.power_step)
                               ? r_heater_power - i_cfg.power_step : '0;
                n_run_count = '0;
            end
        end
    end

    assign o_emit = is_tick && r_data_valid;
    assign o_setpoint = n_heater_power;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_level <= '0;
            r_battery_current <= '0;
            r_phase_a <= '0;
            r_phase_b <= '0;
            r_phase_c <= '0;
            r_data_valid <= 1'b0;
            r_heater_power <= POWER_RESET;
            r_last_was_up <= 1'b1;
            r_run_count <= '0;
        end else if (i_accept) begin
            unique case (i_kind)
                KIND_UPDATE: begin
                    // voltage and unused slots only mark the data as fresh
                    unique case (i_reg_index)
                        SLOT_CHARGE:  r_charge_level <= i_reg_value;
                        SLOT_CURRENT: r_battery_current <= i_reg_value;
                        SLOT_PHASE_A: r_phase_a <= i_reg_value;
                        SLOT_PHASE_B: r_phase_b <= i_reg_value;
                        SLOT_PHASE_C: r_phase_c <= i_reg_value;
                        default: begin
                        end
                    endcase
                    r_data_valid <= 1'b1;
                end
                KIND_ERROR: begin
                    r_data_valid <= 1'b0;
                end
                KIND_TICK: begin
                    if (r_data_valid) begin
                        r_heater_power <= n_heater_power;
                        r_last_was_up <= n_last_was_up;
                        r_run_count <= n_run_count;
                    end else begin
                        r_heater_power <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_stale_tick_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_tick && !r_data_valid |=> r_heater_power == '0)
        else $error("tick without data did not zero the heater power");

    a_error_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_kind == KIND_ERROR) |=> !r_data_valid)
        else $error("read error left data marked valid");

    a_update_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_kind == KIND_UPDATE) |=> r_data_valid)
        else $error("register update did not mark data valid");

    a_emit_tracks_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> r_heater_power == $past(o_setpoint))
        else $error("emitted setpoint differs from stored heater power");

endmodule

[rtl/surplus_heater_power_ramp_unit.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                      | Payload
// ---------+-----------+--------------------------------+----------------------------------------
// in       | input     | i_in_valid / o_in_ready        | i_kind, i_reg_index, i_reg_value,
//          |           |                                | i_heater_on
// out      | output    | o_out_valid / i_out_ready      | o_power_setpoint
// cfg      | input     | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One item per cycle; a tick with valid data shows its setpoint in the cycle after its transfer.
// The output register sets the pace: the input is ready while it is empty or being drained.
// Configuration writes are always ready and take effect on the next cycle.
// Synchronous active-low reset: setpoint 300 W, run count 0, data invalid, repeats 2 and 4.
// A stalled output holds its setpoint and blocks further input transfers.

module surplus_heater_power_ramp_unit
    import shp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_reg_index,
    input  logic [15:0] i_reg_value,
    input  logic        i_heater_on,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_power_setpoint,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg               r_cfg;
    logic               r_out_valid;
    logic [POWER_W-1:0] r_out_power;
    logic               in_accept;
    logic               emit;
    logic [POWER_W-1:0] setpoint;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_step <= CFG_POWER_STEP_RST;
            r_cfg.max_power <= CFG_MAX_POWER_RST;
            r_cfg.repeat_increase <= CFG_REPEAT_INC_RST;
            r_cfg.repeat_decrease <= CFG_REPEAT_DEC_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POWER_STEP: r_cfg.power_step <= i_cfg_data;
                CFG_MAX_POWER:  r_cfg.max_power <= i_cfg_data;
                CFG_REPEAT_INC: r_cfg.repeat_increase <= i_cfg_data[REPEAT_W-1:0];
                CFG_REPEAT_DEC: r_cfg.repeat_decrease <= i_cfg_data[REPEAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    shp_ramp u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_kind      (i_kind),
        .i_reg_index (i_reg_index),
        .i_reg_value (i_reg_value),
        .i_heater_on (i_heater_on),
        .i_cfg       (r_cfg),
        .o_emit      (emit),
        .o_setpoint  (setpoint)
    );

    // result register: refilled whenever it is empty or its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_power <= setpoint;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_power_setpoint = r_out_power;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a pending result");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_out_valid && (o_power_setpoint == $past(setpoint)))
        else $error("emitted setpoint not presented on the output");

    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !emit |=> !o_out_valid)
        else $error("result presented without an emitting item");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import shp_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 80;
    localparam int unsigned CYCLE_LIMIT = 200_000;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PATTERN
    } ready_mode_t;

    // One stimulus row: either a setting write or an input item. Rows with
    // fixed set carry their expected outcome typed in.
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  cfg_sel;
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic [15:0] value;
        logic        heater_on;
        logic        fixed;
        logic        emits;
        logic [15:0] setpoint;
    } ramp_row_t;

    localparam int unsigned DIRECTED_N = 30;
    localparam ramp_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_VOLTAGE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
        // deficit tick straight after reset shows the reset setpoint
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_VOLTAGE, 16'h0000, 1'b0, 1'b1, 1'b1, POWER_RESET},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_CHARGE, 16'd96, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_CURRENT, 16'd1, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_PHASE_A, 16'd2499, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_PHASE_B, 16'd0, 1'b1, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_PHASE_C, 16'd2499, 1'b0, 1'b0, 1'b0, 16'd0},
        // surplus, but setpoint sits above the clamp of 0
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_PHASE_C, 16'hFFFF, 1'b1, 1'b1, 1'b1, POWER_RESET},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_CURRENT, 16'h8000, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_CHARGE, 16'h0000, 1'b1, 1'b1, 1'b1, POWER_RESET},
        '{1'b0, CFG_POWER_STEP, KIND_SPARE, 3'd7, 16'hFFFF, 1'b1, 1'b1, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_ERROR, SLOT_VOLTAGE, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
        // tick without valid data: setpoint cleared, nothing emitted
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_VOLTAGE, 16'h0000, 1'b1, 1'b1, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, 3'd7, 16'h1234, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_VOLTAGE, 16'h0000, 1'b1, 1'b1, 1'b1, 16'd0},
        '{1'b1, CFG_POWER_STEP, KIND_UPDATE, SLOT_VOLTAGE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b1, CFG_MAX_POWER, KIND_UPDATE, SLOT_VOLTAGE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b1, CFG_REPEAT_INC, KIND_UPDATE, SLOT_VOLTAGE, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b1, CFG_REPEAT_DEC, KIND_UPDATE, SLOT_VOLTAGE, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_CURRENT, 16'h7FFF, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_VOLTAGE, 16'h0000, 1'b1, 1'b1, 1'b1, 16'hFFFF},
        // full-scale step on top of full scale stays clamped
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_VOLTAGE, 16'h0000, 1'b1, 1'b1, 1'b1, 16'hFFFF},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_PHASE_C, 16'd2500, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_VOLTAGE, 16'h0000, 1'b1, 1'b1, 1'b1, 16'hFFFF},
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_VOLTAGE, 16'h0000, 1'b0, 1'b1, 1'b1, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_CHARGE, 16'd95, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_PHASE_C, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_VOLTAGE, 16'h0000, 1'b1, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_UPDATE, SLOT_CHARGE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0},
        '{1'b0, CFG_POWER_STEP, KIND_TICK, SLOT_VOLTAGE, 16'h0000, 1'b1, 1'b0, 1'b0, 16'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = KIND_UPDATE;
    logic [2:0]  i_reg_index = SLOT_VOLTAGE;
    logic [15:0] i_reg_value = 16'd0;
    logic        i_heater_on = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_power_setpoint;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_POWER_STEP;
    logic [15:0] i_cfg_data = 16'd0;

    // expectation travelling with the item on the input channel
    logic        row_fixed = 1'b0;
    logic        row_emits = 1'b0;
    logic [15:0] row_setpoint = 16'd0;

    // predictor copy of the block
    t_cfg        ramp_cfg = '{CFG_POWER_STEP_RST, CFG_MAX_POWER_RST,
                              CFG_REPEAT_INC_RST, CFG_REPEAT_DEC_RST};
    logic [15:0] charge_level = 16'd0;
    logic [15:0] battery_current = 16'd0;
    logic [15:0] phase_power [3] = '{16'd0, 16'd0, 16'd0};
    logic        data_valid = 1'b0;
    logic [15:0] heater_power = POWER_RESET;
    logic        last_was_up = 1'b1;
    logic [15:0] run_count = 16'd0;

    logic [15:0] setpoint_q [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned holds_asked = 0;

    surplus_heater_power_ramp_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_reg_index      (i_reg_index),
        .i_reg_value      (i_reg_value),
        .i_heater_on      (i_heater_on),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_power_setpoint (o_power_setpoint),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("surplus_heater_power_ramp_unit test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s, got %0d, expected %0d",
                 cycle_count, what, got, want);
    endtask

    // Apply one item to the predictor; returns 1 when a setpoint comes out.
    function automatic logic ramp_predict(input logic [1:0] kind, input logic [2:0] slot,
                                          input logic [15:0] value, input logic on,
                                          output logic [15:0] setpoint);
        logic        surplus;
        logic [16:0] sum;
        setpoint = heater_power;
        case (kind)
            KIND_UPDATE: begin
                case (slot)
                    SLOT_CHARGE:  charge_level = value;
                    SLOT_CURRENT: battery_current = value;
                    SLOT_PHASE_A: phase_power[0] = value;
                    SLOT_PHASE_B: phase_power[1] = value;
                    SLOT_PHASE_C: phase_power[2] = value;
                    default: ;
                endcase
                data_valid = 1'b1;
                return 1'b0;
            end
            KIND_ERROR: begin
                data_valid = 1'b0;
                return 1'b0;
            end
            KIND_TICK: begin
                if (!data_valid) begin
                    heater_power = 16'd0;
                    return 1'b0;
                end
                surplus = charge_level > SOC_LIMIT
                       && !battery_current[15] && battery_current != 16'd0
                       && phase_power[0] < PHASE_LIMIT
                       && phase_power[1] < PHASE_LIMIT
                       && phase_power[2] < PHASE_LIMIT
                       && on;
                if (surplus) begin
                    if (!last_was_up)
                        run_count = 16'd0;
                    else if (run_count != COUNT_MAX)
                        run_count = run_count + 16'd1;
                    if (heater_power <= ramp_cfg.max_power
                            && run_count >= {8'd0, ramp_cfg.repeat_increase}) begin
                        sum = {1'b0, heater_power} + {1'b0, ramp_cfg.power_step};
                        heater_power = (sum < {1'b0, ramp_cfg.max_power}) ? sum[15:0]
                                                                         : ramp_cfg.max_power;
                        run_count = 16'd0;
                    end
                    last_was_up = 1'b1;
                end else begin
                    if (last_was_up)
                        run_count = 16'd0;
                    else if (run_count != COUNT_MAX)
                        run_count = run_count + 16'd1;
                    if (heater_power != 16'd0
                            && run_count > {8'd0, ramp_cfg.repeat_decrease}) begin
                        heater_power = (heater_power > ramp_cfg.power_step)
                                     ? heater_power - ramp_cfg.power_step : 16'd0;
                        run_count = 16'd0;
                    end
                    last_was_up = 1'b0;
                end
                setpoint = heater_power;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        logic [15:0] predicted;
        logic [15:0] expected;
        logic        emitted;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (setpoint_q.size() == 0) begin
                    report_mismatch("setpoint with nothing pending", o_power_setpoint, 16'd0);
                end else begin
                    expected = setpoint_q.pop_front();
                    if (o_power_setpoint !== expected)
                        report_mismatch("power_setpoint", o_power_setpoint, expected);
                end
            end
            if (i_in_valid && o_in_ready) begin
                emitted = ramp_predict(i_kind, i_reg_index, i_reg_value, i_heater_on,
                                       predicted);
                if (row_fixed) begin
                    if (row_emits)
                        setpoint_q.push_back(row_setpoint);
                end else if (emitted) begin
                    setpoint_q.push_back(predicted);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POWER_STEP: ramp_cfg.power_step = i_cfg_data;
                    CFG_MAX_POWER:  ramp_cfg.max_power = i_cfg_data;
                    CFG_REPEAT_INC: ramp_cfg.repeat_increase = i_cfg_data[7:0];
                    CFG_REPEAT_DEC: ramp_cfg.repeat_decrease = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Output side: stalls follow modes of random length; a requested hold
    // keeps ready low long enough to back the block up into its input.
    always @(posedge i_clk) begin : drain_side
        int unsigned holds_taken;
        int unsigned hold_left;
        int unsigned stretch_left;
        int unsigned pattern_phase;
        ready_mode_t ready_mode;
        if (holds_taken != holds_asked) begin
            holds_taken = holds_asked;
            hold_left = HOLD_CYCLES;
        end
        pattern_phase = pattern_phase + 1;
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                stretch_left = $urandom_range(10, 60);
            end
            stretch_left = stretch_left - 1;
            case (ready_mode)
                RDY_ALWAYS:  i_out_ready <= 1'b1;
                RDY_COIN:    i_out_ready <= ($urandom_range(0, 1) == 0);
                RDY_SPARSE:  i_out_ready <= ($urandom_range(0, 4) == 0);
                default:     i_out_ready <= (pattern_phase % 3 != 0);
            endcase
        end
    end

    task automatic offer_item(input ramp_row_t r);
        int unsigned gap;
        if (i_cfg_valid)
            i_cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = 1;
                2: gap = $urandom_range(2, 4);
                default: gap = $urandom_range(5, 12);
            endcase
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_kind <= r.kind;
        i_reg_index <= r.slot;
        i_reg_value <= r.value;
        i_heater_on <= r.heater_on;
        row_fixed <= r.fixed;
        row_emits <= r.emits;
        row_setpoint <= r.setpoint;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Valid is left high so back-to-back writes need no gap.
    task automatic write_setting(input logic [1:0] sel, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Let every pending setpoint drain, then a few cycles for items that emit nothing.
    // It first waits on the clock so the last transfer's expectation is already queued.
    task automatic settle();
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (setpoint_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_setting(input logic [15:0] top,
                                                 input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return top;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // Mostly well-formed measurement traffic near the surplus thresholds, with
    // errors, ignored kinds and out-of-range values mixed in.
    function automatic ramp_row_t random_item();
        ramp_row_t   r;
        int unsigned pick;
        logic        good;
        logic        coin;
        r = '0;
        pick = $urandom_range(0, 99);
        good = ($urandom_range(0, 99) < 92);
        coin = 1'($urandom_range(0, 1));
        r.slot = 3'($urandom);
        r.value = 16'($urandom);
        r.heater_on = ($urandom_range(0, 5) != 0);
        if (pick < 55) begin
            r.kind = KIND_TICK;
        end else if (pick < 91) begin
            r.kind = KIND_UPDATE;
            case (r.slot)
                SLOT_CHARGE:
                    if (good) r.value = 16'($urandom_range(96, 120));
                    else if (coin) r.value = 16'($urandom_range(80, 95));
                SLOT_CURRENT:
                    if (good) r.value = 16'($urandom_range(1, 3000));
                    else if (coin) r.value = 16'd0;
                SLOT_PHASE_A, SLOT_PHASE_B, SLOT_PHASE_C:
                    if (good) r.value = 16'($urandom_range(0, 2499));
                    else if (coin) r.value = 16'($urandom_range(2500, 2600));
                default: ;
            endcase
        end else if (pick < 96) begin
            r.kind = KIND_ERROR;
        end else begin
            r.kind = KIND_SPARE;
        end
        return r;
    endfunction

    initial begin : stimulus
        ramp_row_t r;
        logic      prev_cfg;
        prev_cfg = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[n]) begin
            r = DIRECTED_ROWS[n];
            if (r.is_cfg) begin
                if (!prev_cfg)
                    settle();
                write_setting(r.cfg_sel, r.value);
            end else begin
                offer_item(r);
            end
            prev_cfg = r.is_cfg;
        end

        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            if (phase == 0) begin
                write_setting(CFG_POWER_STEP, 16'd0);
                write_setting(CFG_MAX_POWER, 16'd0);
                write_setting(CFG_REPEAT_INC, 16'd255);
                write_setting(CFG_REPEAT_DEC, 16'd255);
            end else begin
                write_setting(CFG_POWER_STEP, pick_setting(16'hFFFF, 1, 800));
                write_setting(CFG_MAX_POWER, pick_setting(16'hFFFF, 200, 4000));
                write_setting(CFG_REPEAT_INC, pick_setting(16'd255, 0, 5));
                write_setting(CFG_REPEAT_DEC, pick_setting(16'd255, 0, 5));
            end
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == 10)
                    holds_asked++;
                offer_item(random_item());
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("surplus_heater_power_ramp_unit test passed");
        else
            $display("surplus_heater_power_ramp_unit test failed");
        $finish;
    end

endmodule
